@@ rtl/dee_pkg.sv @@
// Shared constants and types for the disk extent estimator.
// Field widths, configuration register indexes and their reset values.
// No dependencies.
`default_nettype none

package dee_pkg;

   // Field widths
   localparam int SAMPLE_W   = 20;
   localparam int DIM_W      = 13;
   localparam int THR_W      = 19;
   localparam int TOL_W      = 14;
   localparam int DIFF_W     = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 19;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_ROWS,
      CSR_FRAME_COLS,
      CSR_LEVEL_THRESHOLD,
      CSR_DISAGREE_TOL
   } csr_index_type;

   // Register reset values
   localparam logic [DIM_W-1:0] FRAME_ROWS_RST = 13'd4096;
   localparam logic [DIM_W-1:0] FRAME_COLS_RST = 13'd4096;
   localparam logic [THR_W-1:0] THRESHOLD_RST  = 19'd16;
   localparam logic [TOL_W-1:0] TOLERANCE_RST  = 14'd20;

endpackage

`default_nettype wire

@@ rtl/disk_extent_estimator_top.sv @@
// Disk extent estimator: per-pixel extent tracking and end-of-frame result pipeline.
// Depends on dee_pkg for widths, register indexes and reset values.
//
// Throughput: one pixel per cycle while req_stall is low; the tracker updates in the accept cycle.
// Result path: the last pixel of a frame is registered through the final tracker capture,
// the sum stage and the difference/compare stage into the output register.
// Reset: synchronous; clears raster counters, trackers, pipeline valids and restores
// the configuration registers to their defaults.
`default_nettype none

module disk_extent_estimator_top #(
   parameter int MAX_DIM = 4096
) (
   input  wire                               clock,
   input  wire                               reset,
   // pixel input
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire signed [dee_pkg::SAMPLE_W-1:0] req_sample,
   // result output
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [dee_pkg::DIM_W-1:0]         rsp_center_x_half,
   output logic [dee_pkg::DIM_W-1:0]         rsp_center_y_half,
   output logic [dee_pkg::DIM_W-1:0]         rsp_radius_quarter,
   output logic                              rsp_disk_found,
   output logic [dee_pkg::DIFF_W-1:0]        rsp_max_difference,
   output logic                              rsp_estimators_disagree,
   // configuration writes
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [dee_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [dee_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW     = $clog2(MAX_DIM);
   localparam int DIM_W  = dee_pkg::DIM_W;
   localparam int THR_W  = dee_pkg::THR_W;
   localparam int TOL_W  = dee_pkg::TOL_W;
   localparam int DIFF_W = dee_pkg::DIFF_W;
   localparam int SAM_W  = dee_pkg::SAMPLE_W;

   typedef struct packed {
      logic [CW-1:0] row_first;
      logic [CW-1:0] row_last;
      logic          row_seen;
      logic [CW-1:0] col_first;
      logic [CW-1:0] col_last;
      logic          col_seen;
      logic [CW-1:0] left;
      logic [CW-1:0] right;
      logic [CW-1:0] top;
      logic [CW-1:0] bottom;
      logic          box_seen;
   } track_type;

   typedef struct packed {
      logic [CW:0]   cx2;
      logic [CW:0]   cy2;
      logic [CW+1:0] r4;       // two's complement; the row span can run backward
      logic [CW:0]   bx2;
      logic [CW:0]   by2;
      logic [CW:0]   br4;
      logic          found;
      logic          box_seen;
   } sums_type;

   // clamp a dimension register to 1..MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [CW:0] abs_diff(input logic [CW:0] a, input logic [CW:0] b);
      logic [CW:0] r;
      if (a > b) begin
         r = a - b;
      end else begin
         r = b - a;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Configuration registers
   logic [DIM_W-1:0] rows_ff, cols_ff;
   logic [THR_W-1:0] thr_ff;
   logic [TOL_W-1:0] tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= dee_pkg::FRAME_ROWS_RST;
         cols_ff <= dee_pkg::FRAME_COLS_RST;
         thr_ff  <= dee_pkg::THRESHOLD_RST;
         tol_ff  <= dee_pkg::TOLERANCE_RST;
      end else if (csr_valid && csr_ready) begin
         case (dee_pkg::csr_index_type'(csr_index))
            dee_pkg::CSR_FRAME_ROWS:      rows_ff <= csr_data[DIM_W-1:0];
            dee_pkg::CSR_FRAME_COLS:      cols_ff <= csr_data[DIM_W-1:0];
            dee_pkg::CSR_LEVEL_THRESHOLD: thr_ff  <= csr_data[THR_W-1:0];
            dee_pkg::CSR_DISAGREE_TOL:    tol_ff  <= csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline flow control
   logic fin_valid_ff, sum_valid_ff, rsp_valid_ff;
   logic out_ready, sum_ready, fin_ready;
   logic req_accept;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign sum_ready  = !sum_valid_ff || out_ready;
   assign fin_ready  = !fin_valid_ff || sum_ready;
   assign req_stall  = !fin_ready;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // Pixel classification and raster position
   logic [DIM_W-1:0] rows_eff, cols_eff;
   logic [CW-1:0]    row_mid, col_mid, row_lastidx, col_lastidx;
   logic [SAM_W:0]   sample_ext, mag;
   logic             on_disk;
   logic [CW-1:0]    x_ff, y_ff, x_in, y_in;
   logic             row_end, frame_end;

   always_comb begin
      rows_eff    = eff_dim(rows_ff);
      cols_eff    = eff_dim(cols_ff);
      row_mid     = rows_eff[CW:1];
      col_mid     = cols_eff[CW:1];
      row_lastidx = CW'(rows_eff - DIM_W'(1));
      col_lastidx = CW'(cols_eff - DIM_W'(1));
      // magnitude; the most negative sample maps to 2^19
      sample_ext  = {req_sample[SAM_W-1], req_sample};
      mag         = req_sample[SAM_W-1] ? ((SAM_W+1)'(0) - sample_ext) : sample_ext;
      on_disk     = mag > (SAM_W+1)'(thr_ff);
      row_end     = x_ff >= col_lastidx;
      frame_end   = row_end && (y_ff >= row_lastidx);
   end

   // next raster position
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (req_accept) begin
         if (frame_end) begin
            x_in = '0;
            y_in = '0;
         end else if (row_end) begin
            x_in = '0;
            y_in = y_ff + CW'(1);
         end else begin
            x_in = x_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   // ---------------------------------------------------------------
   // Extent trackers: central row, central column, bounding box
   track_type tr_ff, tr_in, tr_upd;

   always_comb begin
      tr_upd = tr_ff;
      if (on_disk) begin
         if (y_ff == row_mid) begin
            if (!tr_ff.row_seen) begin
               tr_upd.row_first = x_ff;
            end
            tr_upd.row_last = x_ff;
            tr_upd.row_seen = 1'b1;
         end
         if (x_ff == col_mid) begin
            if (!tr_ff.col_seen) begin
               tr_upd.col_first = y_ff;
            end
            tr_upd.col_last = y_ff;
            tr_upd.col_seen = 1'b1;
         end
         if (!tr_ff.box_seen) begin
            tr_upd.left     = x_ff;
            tr_upd.right    = x_ff;
            tr_upd.top      = y_ff;
            tr_upd.bottom   = y_ff;
            tr_upd.box_seen = 1'b1;
         end else begin
            if (x_ff < tr_ff.left)   tr_upd.left   = x_ff;
            if (x_ff > tr_ff.right)  tr_upd.right  = x_ff;
            if (y_ff < tr_ff.top)    tr_upd.top    = y_ff;
            if (y_ff > tr_ff.bottom) tr_upd.bottom = y_ff;
         end
      end
   end

   always_comb begin
      tr_in = tr_ff;
      if (req_accept) begin
         tr_in = frame_end ? '0 : tr_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tr_ff <= '0;
      end else begin
         tr_ff <= tr_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: capture the final trackers of a frame
   track_type fin_ff;
   logic      fin_load;

   assign fin_load = req_accept && frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (fin_ready) begin
         fin_valid_ff <= fin_load;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_load) begin
         fin_ff <= tr_upd;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: centers and spans of both estimators
   sums_type sum_ff, sum_in;

   always_comb begin
      sum_in.cx2      = {1'b0, fin_ff.row_first} + {1'b0, fin_ff.row_last};
      sum_in.cy2      = {1'b0, fin_ff.col_first} + {1'b0, fin_ff.col_last};
      // the central row may move after a resize, so its span can be negative
      sum_in.r4       = {2'b0, fin_ff.row_last} - {2'b0, fin_ff.row_first}
                      + {2'b0, fin_ff.col_last} - {2'b0, fin_ff.col_first};
      sum_in.bx2      = {1'b0, fin_ff.left} + {1'b0, fin_ff.right};
      sum_in.by2      = {1'b0, fin_ff.top} + {1'b0, fin_ff.bottom};
      sum_in.br4      = {1'b0, fin_ff.right - fin_ff.left}
                      + {1'b0, fin_ff.bottom - fin_ff.top};
      sum_in.found    = fin_ff.row_seen && fin_ff.col_seen;
      sum_in.box_seen = fin_ff.box_seen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (sum_ready) begin
         sum_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && fin_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: estimator disagreement and output register
   logic [DIFF_W-1:0] d_cx, d_cy, d_r, diff_max, r4_ext;
   logic              r4_neg;
   logic [DIM_W-1:0]  cx_in, cy_in, r_in;
   logic              found_in, disagree_in;
   logic [DIFF_W-1:0] maxd_in;
   logic [DIM_W-1:0]  cx_ff, cy_ff, r_ff;
   logic              found_ff, disagree_ff;
   logic [DIFF_W-1:0] maxd_ff;

   always_comb begin
      d_cx     = DIFF_W'({abs_diff(sum_ff.cx2, sum_ff.bx2), 1'b0});
      d_cy     = DIFF_W'({abs_diff(sum_ff.cy2, sum_ff.by2), 1'b0});
      // a negative span sum wraps to a huge unsigned value: it wins the max
      // and always exceeds the tolerance; only its low bits are reported
      r4_neg   = sum_ff.r4[CW+1];
      r4_ext   = DIFF_W'(signed'(sum_ff.r4));
      if (r4_neg) begin
         d_r = r4_ext - DIFF_W'(sum_ff.br4);
      end else begin
         d_r = DIFF_W'(abs_diff(sum_ff.r4[CW:0], sum_ff.br4));
      end
      diff_max = '0;
      if (sum_ff.box_seen) begin
         if (r4_neg) begin
            diff_max = d_r;
         end else begin
            diff_max = (d_cx > d_cy) ? d_cx : d_cy;
            if (d_r > diff_max) diff_max = d_r;
         end
      end
      // nothing found: every field reads zero
      cx_in       = '0;
      cy_in       = '0;
      r_in        = '0;
      found_in    = 1'b0;
      maxd_in     = '0;
      disagree_in = 1'b0;
      if (sum_ff.found) begin
         cx_in       = DIM_W'(sum_ff.cx2);
         cy_in       = DIM_W'(sum_ff.cy2);
         r_in        = DIM_W'(signed'(sum_ff.r4));
         found_in    = 1'b1;
         maxd_in     = diff_max;
         disagree_in = (sum_ff.box_seen && r4_neg) || (diff_max > DIFF_W'(tol_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && sum_valid_ff) begin
         cx_ff       <= cx_in;
         cy_ff       <= cy_in;
         r_ff        <= r_in;
         found_ff    <= found_in;
         maxd_ff     <= maxd_in;
         disagree_ff <= disagree_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_center_x_half       = cx_ff;
   assign rsp_center_y_half       = cy_ff;
   assign rsp_radius_quarter      = r_ff;
   assign rsp_disk_found          = found_ff;
   assign rsp_max_difference      = maxd_ff;
   assign rsp_estimators_disagree = disagree_ff;

   // ---------------------------------------------------------------
   // Assertions

   // a result without a disk carries only zeros
   a_zero_when_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |->
         cx_ff == '0 && cy_ff == '0 && r_ff == '0 && maxd_ff == '0 && !disagree_ff)
      else $error("result without disk has nonzero fields");

   // the last pixel of a frame always lands in the capture stage
   a_frame_end_capture: assert property (@(posedge clock) disable iff (reset)
      req_accept && frame_end |=> fin_valid_ff)
      else $error("frame end not captured");

   // a blocked capture stage keeps its frame
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff && !sum_ready |=> fin_valid_ff && $stable(fin_ff))
      else $error("captured frame lost while blocked");

   // trackers are clear right after a frame ends
   a_clear_after_frame: assert property (@(posedge clock) disable iff (reset)
      req_accept && frame_end |=> tr_ff == '0 && x_ff == '0 && y_ff == '0)
      else $error("frame state not cleared");

endmodule

`default_nettype wire

@@ verif/tb_disk_extent_estimator_top.sv @@
// Testbench for disk_extent_estimator_top: streams raster frames of Q16.4 samples,
// predicts each end-of-frame extent result and checks every result beat in order.
// Depends on dee_pkg and the disk_extent_estimator_top RTL.
`default_nettype none

module tb_disk_extent_estimator_top;

   localparam int SAMPLE_W         = dee_pkg::SAMPLE_W;
   localparam int DIM_W            = dee_pkg::DIM_W;
   localparam int THR_W            = dee_pkg::THR_W;
   localparam int TOL_W            = dee_pkg::TOL_W;
   localparam int DIFF_W           = dee_pkg::DIFF_W;
   localparam int CSR_IDX_W        = dee_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W       = dee_pkg::CSR_DATA_W;
   localparam int MAX_DIM          = 4096;
   localparam int CLOCK_PERIOD     = 8;
   localparam int MAX_WAIT         = 18;
   // room for every late beat: three buffered results, each held off by a drawn result-side wait
   localparam int PIPE_DRAIN       = 4 * (MAX_WAIT + 2);
   localparam int RANDOM_ITEMS     = 600;
   localparam int RUN_LIMIT_CYCLES = 1000000;
   localparam int SAMPLE_MAG_MAX   = 1 << (SAMPLE_W - 1);
   localparam int THRESHOLD_MAX    = (1 << THR_W) - 1;
   localparam int TOLERANCE_MAX    = (1 << TOL_W) - 1;
   localparam int DIM_FIELD_MAX    = (1 << DIM_W) - 1;

   typedef struct packed {
      logic [DIM_W-1:0]  center_x_half;
      logic [DIM_W-1:0]  center_y_half;
      logic [DIM_W-1:0]  radius_quarter;
      logic              disk_found;
      logic [DIFF_W-1:0] max_difference;
      logic              estimators_disagree;
   } extent_result_type;

   typedef struct {
      dee_pkg::csr_index_type idx;
      logic [CSR_DATA_W-1:0]  data;
   } reg_write_type;

   typedef enum {SHAPE_DISK, SHAPE_NOISY, SHAPE_EMPTY, SHAPE_FULL, SHAPE_RAW} shape_kind_type;

   // Tracks frame position and both estimators; queues the result of each closed frame
   class extent_scoreboard;
      logic [DIM_W-1:0] rows_reg, cols_reg;
      logic [THR_W-1:0] threshold_reg;
      logic [TOL_W-1:0] tolerance_reg;
      int col_pos, row_pos;
      int row_first, row_last, col_first, col_last;
      int box_left, box_right, box_top, box_bottom;
      bit row_hit, col_hit, box_hit;
      extent_result_type expected_q[$];
      int errors;
      int results_checked;

      function new();
         rows_reg        = dee_pkg::FRAME_ROWS_RST;
         cols_reg        = dee_pkg::FRAME_COLS_RST;
         threshold_reg   = dee_pkg::THRESHOLD_RST;
         tolerance_reg   = dee_pkg::TOLERANCE_RST;
         errors          = 0;
         results_checked = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         col_pos   = 0;  row_pos    = 0;
         row_first = 0;  row_last   = 0;  row_hit = 1'b0;
         col_first = 0;  col_last   = 0;  col_hit = 1'b0;
         box_left  = 0;  box_right  = 0;
         box_top   = 0;  box_bottom = 0;  box_hit = 1'b0;
      endfunction

      // zero acts as one, anything above the maximum clamps
      function int rows_eff();
         return (rows_reg == 0) ? 1 : ((rows_reg > MAX_DIM) ? MAX_DIM : int'(rows_reg));
      endfunction

      function int cols_eff();
         return (cols_reg == 0) ? 1 : ((cols_reg > MAX_DIM) ? MAX_DIM : int'(cols_reg));
      endfunction

      function void write_reg(dee_pkg::csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            dee_pkg::CSR_FRAME_ROWS:      rows_reg      = data[DIM_W-1:0];
            dee_pkg::CSR_FRAME_COLS:      cols_reg      = data[DIM_W-1:0];
            dee_pkg::CSR_LEVEL_THRESHOLD: threshold_reg = data[THR_W-1:0];
            dee_pkg::CSR_DISAGREE_TOL:    tolerance_reg = data[TOL_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(logic signed [SAMPLE_W-1:0] value);
         int mag, x, y, rows, cols;
         int unsigned cx2, cy2, r4, bx2, by2, br4, diff, d;
         bit lit;
         extent_result_type res;
         mag  = (value < 0) ? -int'(value) : int'(value);
         lit  = mag > int'(threshold_reg);
         rows = rows_eff();
         cols = cols_eff();
         x    = col_pos;
         y    = row_pos;

         // central row, central column and bounding box updates
         if (lit) begin
            if (y == rows / 2) begin
               if (!row_hit) begin
                  row_first = x;
                  row_hit   = 1'b1;
               end
               row_last = x;
            end
            if (x == cols / 2) begin
               if (!col_hit) begin
                  col_first = y;
                  col_hit   = 1'b1;
               end
               col_last = y;
            end
            if (!box_hit) begin
               box_left = x;  box_right  = x;
               box_top  = y;  box_bottom = y;
               box_hit  = 1'b1;
            end else begin
               if (x < box_left)   box_left   = x;
               if (x > box_right)  box_right  = x;
               if (y < box_top)    box_top    = y;
               if (y > box_bottom) box_bottom = y;
            end
         end

         // raster advance; a counter past the last index counts as the last one
         if (x < cols - 1) begin
            col_pos = x + 1;
            return;
         end
         if (y < rows - 1) begin
            col_pos = 0;
            row_pos = y + 1;
            return;
         end

         // frame end: all zero unless both central lines were hit;
         // spans are 32-bit unsigned, so a backward row span wraps
         res = '0;
         if (row_hit && col_hit) begin
            cx2  = unsigned'(row_first + row_last);
            cy2  = unsigned'(col_first + col_last);
            r4   = unsigned'((row_last - row_first) + (col_last - col_first));
            diff = 0;
            if (box_hit) begin
               bx2  = unsigned'(box_left + box_right);
               by2  = unsigned'(box_top + box_bottom);
               br4  = unsigned'((box_right - box_left) + (box_bottom - box_top));
               d    = 32'd2 * ((cx2 > bx2) ? cx2 - bx2 : bx2 - cx2);
               diff = (d > diff) ? d : diff;
               d    = 32'd2 * ((cy2 > by2) ? cy2 - by2 : by2 - cy2);
               diff = (d > diff) ? d : diff;
               d    = (r4 > br4) ? r4 - br4 : br4 - r4;
               diff = (d > diff) ? d : diff;
            end
            res.center_x_half       = cx2[DIM_W-1:0];
            res.center_y_half       = cy2[DIM_W-1:0];
            res.radius_quarter      = r4[DIM_W-1:0];
            res.disk_found          = 1'b1;
            res.max_difference      = diff[DIFF_W-1:0];
            res.estimators_disagree = diff > 32'(tolerance_reg);
         end
         expected_q = {expected_q, res};
         clear_frame();
      endfunction

      function void flag_error(string what);
         errors++;
         if (errors <= 10) $display("%s", what);
      endfunction

      function void check_result(extent_result_type got);
         extent_result_type want;
         results_checked++;
         if (expected_q.size() == 0) begin
            flag_error($sformatf("result beat %0d with no frame closed", results_checked));
            return;
         end
         want = expected_q.pop_front();
         if (got.center_x_half !== want.center_x_half ||
             got.center_y_half !== want.center_y_half ||
             got.radius_quarter !== want.radius_quarter ||
             got.disk_found !== want.disk_found ||
             got.max_difference !== want.max_difference ||
             got.estimators_disagree !== want.estimators_disagree) begin
            flag_error({
               $sformatf("result %0d: exp cx %0d cy %0d r %0d found %0b diff %0d dis %0b,",
                  results_checked,
                  want.center_x_half, want.center_y_half, want.radius_quarter,
                  want.disk_found, want.max_difference, want.estimators_disagree),
               $sformatf(" got cx %0d cy %0d r %0d found %0b diff %0d dis %0b",
                  got.center_x_half, got.center_y_half, got.radius_quarter,
                  got.disk_found, got.max_difference, got.estimators_disagree)});
         end
      endfunction
   endclass

   // clock and DUT signals
   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic rsp_valid, rsp_stall;
   logic [DIM_W-1:0] rsp_center_x_half, rsp_center_y_half, rsp_radius_quarter;
   logic rsp_disk_found;
   logic [DIFF_W-1:0] rsp_max_difference;
   logic rsp_estimators_disagree;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   extent_scoreboard sb;
   reg_write_type reg_writes[$];

   // idle-stretch state, one set per side
   int req_left = 0, rsp_left = 0;
   bit req_calm = 1'b0, rsp_calm = 1'b0;

   // current test image, redrawn at the start of every frame
   shape_kind_type shape_mode = SHAPE_DISK;
   int disk_cx2 = 0, disk_cy2 = 0, disk_r2 = 0;

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   disk_extent_estimator_top u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_sample              (req_sample),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_center_x_half       (rsp_center_x_half),
      .rsp_center_y_half       (rsp_center_y_half),
      .rsp_radius_quarter      (rsp_radius_quarter),
      .rsp_disk_found          (rsp_disk_found),
      .rsp_max_difference      (rsp_max_difference),
      .rsp_estimators_disagree (rsp_estimators_disagree),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   // per-beat wait: drawn at random, with occasional stretches of no waiting
   function automatic int draw_wait(ref int left, ref bit calm);
      if (left == 0) begin
         left = $urandom_range(1, 40);
         calm = ($urandom_range(0, 2) == 0);
      end
      left--;
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // sample above or at/below the current threshold, random sign
   function automatic logic signed [SAMPLE_W-1:0] level_sample(bit lit);
      int level, mag;
      level = int'(sb.threshold_reg);
      if (lit) mag = ($urandom_range(0, 7) == 0) ? level + 1
                                                 : $urandom_range(level + 1, SAMPLE_MAG_MAX);
      else     mag = ($urandom_range(0, 7) == 0) ? level : $urandom_range(0, level);
      if (mag == SAMPLE_MAG_MAX || (mag != 0 && $urandom_range(0, 1) == 1)) mag = -mag;
      return SAMPLE_W'(mag);
   endfunction

   function automatic void draw_shape();
      int rows, cols;
      rows = sb.rows_eff();
      cols = sb.cols_eff();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: shape_mode = SHAPE_DISK;
         6:                shape_mode = SHAPE_NOISY;
         7:                shape_mode = SHAPE_EMPTY;
         8:                shape_mode = SHAPE_FULL;
         default:          shape_mode = SHAPE_RAW;
      endcase
      // centers mostly on the central lines so the disk is usually found
      disk_cx2 = $urandom_range(0, 1) ? cols - 1 : $urandom_range(0, 2 * (cols - 1));
      disk_cy2 = $urandom_range(0, 1) ? rows - 1 : $urandom_range(0, 2 * (rows - 1));
      disk_r2  = $urandom_range(0, 2 * ((rows > cols) ? rows : cols));
   endfunction

   // next pixel of the current image, placed by the predicted raster position
   function automatic logic signed [SAMPLE_W-1:0] next_sample();
      int dx, dy;
      bit lit;
      if (sb.col_pos == 0 && sb.row_pos == 0) draw_shape();
      if (shape_mode == SHAPE_RAW) return SAMPLE_W'($urandom());
      dx  = 2 * sb.col_pos - disk_cx2;
      dy  = 2 * sb.row_pos - disk_cy2;
      lit = (shape_mode == SHAPE_FULL) ||
            (shape_mode != SHAPE_EMPTY && dx * dx + dy * dy <= disk_r2 * disk_r2);
      if ($urandom_range(0, (shape_mode == SHAPE_NOISY) ? 5 : 39) == 0) lit = !lit;
      return level_sample(lit);
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(0, 19))
         0:                  return 0;
         1:                  return 1;
         16, 17, 18:         return $urandom_range(9, 20);
         default:            return $urandom_range(2, 8);
      endcase
   endfunction

   task automatic send_pixel(input logic signed [SAMPLE_W-1:0] value);
      int gap;
      gap = draw_wait(req_left, req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_pixel(value);
   endtask

   function automatic void queue_write(dee_pkg::csr_index_type idx, int data);
      reg_write_type w;
      w.idx  = idx;
      w.data = CSR_DATA_W'(data);
      reg_writes = {reg_writes, w};
   endfunction

   // register writes back to back, one beat per write
   task automatic apply_writes();
      reg_write_type w;
      while (reg_writes.size() > 0) begin
         w = reg_writes.pop_front();
         csr_valid <= 1'b1;
         csr_index <= w.idx;
         csr_data  <= w.data;
         do @(posedge clock); while (csr_ready !== 1'b1);
         sb.write_reg(w.idx, w.data);
      end
      csr_valid <= 1'b0;
   endtask

   // stop the pixel stream, wait for every pending result, then let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // result side: hold off for a drawn number of cycles once a beat is waiting
   task automatic watch_results();
      int hold;
      extent_result_type got;
      forever begin
         hold = draw_wait(rsp_left, rsp_calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (rsp_valid !== 1'b1);
            repeat (hold - 1) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.center_x_half       = rsp_center_x_half;
         got.center_y_half       = rsp_center_y_half;
         got.radius_quarter      = rsp_radius_quarter;
         got.disk_found          = rsp_disk_found;
         got.max_difference      = rsp_max_difference;
         got.estimators_disagree = rsp_estimators_disagree;
         sb.check_result(got);
      end
   endtask

   initial begin
      int random_items, area, count, level, tol;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_sample = '0;
      rsp_stall  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = dee_pkg::CSR_FRAME_ROWS;
      csr_data   = '0;
      sb         = new();
      random_items = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      fork
         watch_results();
      join_none

      // single-pixel frames at the top threshold: only the most negative sample is on
      queue_write(dee_pkg::CSR_FRAME_ROWS, 1);
      queue_write(dee_pkg::CSR_FRAME_COLS, 1);
      queue_write(dee_pkg::CSR_LEVEL_THRESHOLD, THRESHOLD_MAX);
      queue_write(dee_pkg::CSR_DISAGREE_TOL, 0);
      apply_writes();
      send_pixel(20'sh80000);
      send_pixel(20'sh7FFFF);
      settle();

      // zero rows acts as one row; zero threshold makes any nonzero sample on
      queue_write(dee_pkg::CSR_FRAME_ROWS, 0);
      queue_write(dee_pkg::CSR_FRAME_COLS, 3);
      queue_write(dee_pkg::CSR_LEVEL_THRESHOLD, 0);
      apply_writes();
      send_pixel(20'sd0);
      send_pixel(20'sd1);
      send_pixel(20'sd0);
      settle();

      // 3x3 diagonal: centers agree, box radius differs, tolerance exceeded
      queue_write(dee_pkg::CSR_FRAME_ROWS, 3);
      queue_write(dee_pkg::CSR_FRAME_COLS, 3);
      queue_write(dee_pkg::CSR_LEVEL_THRESHOLD, 16);
      queue_write(dee_pkg::CSR_DISAGREE_TOL, 3);
      apply_writes();
      for (int i = 0; i < 9; i++) send_pixel((i % 4 == 0) ? 20'sd17 : -20'sd16);
      settle();

      // shrink the frame mid-way: the column counter lands past the new last column
      queue_write(dee_pkg::CSR_FRAME_ROWS, 4);
      queue_write(dee_pkg::CSR_FRAME_COLS, 4);
      apply_writes();
      repeat (6) send_pixel(20'sd100);
      settle();
      queue_write(dee_pkg::CSR_FRAME_ROWS, 2);
      queue_write(dee_pkg::CSR_FRAME_COLS, 2);
      apply_writes();
      send_pixel(20'sd100);
      settle();

      // largest row count and an oversized column count, closed early by a resize
      queue_write(dee_pkg::CSR_FRAME_ROWS, MAX_DIM);
      queue_write(dee_pkg::CSR_FRAME_COLS, DIM_FIELD_MAX);
      queue_write(dee_pkg::CSR_DISAGREE_TOL, TOLERANCE_MAX);
      apply_writes();
      repeat (24) send_pixel(next_sample());
      settle();
      queue_write(dee_pkg::CSR_FRAME_ROWS, 1);
      queue_write(dee_pkg::CSR_FRAME_COLS, 4);
      apply_writes();
      send_pixel(next_sample());

      // random phases of small frames, sometimes ending mid-frame before a reconfig
      while (random_items < RANDOM_ITEMS) begin
         settle();
         if ($urandom_range(0, 1)) queue_write(dee_pkg::CSR_FRAME_ROWS, pick_dim());
         if ($urandom_range(0, 1)) queue_write(dee_pkg::CSR_FRAME_COLS, pick_dim());
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0:       level = 0;
               1:       level = THRESHOLD_MAX;
               2:       level = int'(dee_pkg::THRESHOLD_RST);
               3, 4:    level = $urandom_range(0, 4095);
               default: level = $urandom_range(0, THRESHOLD_MAX);
            endcase
            queue_write(dee_pkg::CSR_LEVEL_THRESHOLD, level);
         end
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
               0:       tol = 0;
               1:       tol = TOLERANCE_MAX;
               2:       tol = $urandom_range(0, 40);
               default: tol = $urandom_range(0, TOLERANCE_MAX);
            endcase
            queue_write(dee_pkg::CSR_DISAGREE_TOL, tol);
         end
         apply_writes();
         area  = sb.rows_eff() * sb.cols_eff();
         count = area * ((area > 64) ? 1 : $urandom_range(1, 3));
         if (area > 1 && $urandom_range(0, 3) == 0) count += $urandom_range(1, area - 1);
         // keep the stream near its planned length
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         repeat (count) send_pixel(next_sample());
         random_items += count;
      end

      settle();
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("tb_disk_extent_estimator_top: clean");
      end else begin
         $display("tb_disk_extent_estimator_top: errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #(CLOCK_PERIOD * RUN_LIMIT_CYCLES);
      $display("tb_disk_extent_estimator_top: errors");
      $finish;
   end

endmodule

`default_nettype wire
